/* src/irpir_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse interval receiver package
// Shared widths, codes and the structs that pass between the face lanes,
// the merge stage and the top level.
// ----------------------------------------------------------------------------
package irpir_pkg;

   localparam int FACES   = 6;
   localparam int FACE_W  = 3;
   localparam int STAMP_W = 8;
   localparam int GAP_W   = 9;
   localparam int VALUE_W = 8;
   localparam int OVF_W   = 6;
   localparam int CSR_W   = 2;

   // A value is full when its bits 3:2 read 01.
   localparam logic [VALUE_W-1:0] FULL_MASK = 8'h0C;
   localparam logic [VALUE_W-1:0] FULL_CODE = 8'h04;

   // One full timer period, used when a face has seen one wrap.
   localparam logic [GAP_W:0] TIMER_SPAN = 10'd256;

   localparam logic [GAP_W-1:0] GAP_MIN_RST   = 9'd10;
   localparam logic [GAP_W-1:0] GAP_MAX_RST   = 9'd300;
   localparam logic [GAP_W-1:0] ONE_LIMIT_RST = 9'd200;

   typedef enum logic [1:0] {
      OP_WRAP  = 2'd0,
      OP_PULSE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_GAP_MIN   = 2'd0,
      CSR_GAP_MAX   = 2'd1,
      CSR_ONE_LIMIT = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAP_W-1:0] gap_min;
      logic [GAP_W-1:0] gap_max;
      logic [GAP_W-1:0] one_limit;
   } cfg_type;

   typedef struct packed {
      logic               wrap;
      logic               pulse;
      logic               read;
      logic [STAMP_W-1:0] stamp;
   } lane_cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] rd;
      logic               ovf;
   } lane_res_type;

endpackage
`default_nettype wire

/* src/irpir_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse interval receiver face lane
// Timing flags, last stamp, shift value and sticky overflow of one face.
// ----------------------------------------------------------------------------
module irpir_lane (
   input  wire                          clock,
   input  wire                          reset,
   input  wire irpir_pkg::cfg_type      cfg,
   input  wire irpir_pkg::lane_cmd_type cmd,
   output irpir_pkg::lane_res_type      res
);
   import irpir_pkg::*;

   logic [STAMP_W-1:0] last_ff, last_in;
   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic               wrapped_ff, wrapped_in;
   logic               expired_ff, expired_in;
   logic               ovf_ff, ovf_in;

   logic [GAP_W:0]   gap_wrap;
   logic [GAP_W-1:0] gap;
   logic             gap_ok;
   logic             full;

   assign gap_wrap = TIMER_SPAN - {2'b00, last_ff} + {2'b00, cmd.stamp};
   assign full     = (shift_ff & FULL_MASK) == FULL_CODE;

   always_comb begin
      if (wrapped_ff) begin
         gap    = gap_wrap[GAP_W-1:0];
         gap_ok = 1'b1;
      end else begin
         gap    = {1'b0, cmd.stamp - last_ff};
         gap_ok = cmd.stamp >= last_ff;
      end
      gap_ok = gap_ok && (gap < cfg.gap_max) && (gap > cfg.gap_min);
   end

   always_comb begin
      last_in    = last_ff;
      shift_in   = shift_ff;
      wrapped_in = wrapped_ff;
      expired_in = expired_ff;
      ovf_in     = ovf_ff;
      res.rd     = '0;
      if (cmd.wrap) begin
         expired_in = expired_ff | wrapped_ff;
         wrapped_in = 1'b1;
      end
      if (cmd.pulse) begin
         if (!expired_ff) begin
            if (gap_ok) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  shift_in = {shift_ff[VALUE_W-2:0], gap <= cfg.one_limit};
               end
            end else begin
               shift_in = '0;
            end
         end
         last_in    = cmd.stamp;
         wrapped_in = 1'b0;
         expired_in = 1'b0;
      end
      if (cmd.read && full) begin
         shift_in = '0;
         res.rd   = shift_ff;
      end
      res.ovf = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         shift_ff   <= '0;
         wrapped_ff <= 1'b0;
         expired_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         last_ff    <= last_in;
         shift_ff   <= shift_in;
         wrapped_ff <= wrapped_in;
         expired_ff <= expired_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule
`default_nettype wire

/* src/irpir_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse interval receiver merge stage
// Combines the lane results into one result item and holds it for the sink.
// ----------------------------------------------------------------------------
module irpir_merge (
   input  wire                                               clock,
   input  wire                                               reset,
   input  wire                                               accept,
   input  wire irpir_pkg::lane_res_type [irpir_pkg::FACES-1:0] lane_res,
   input  wire                                               rsp_tready,
   output logic                                              rsp_tvalid,
   output logic [15:0]                                       rsp_tdata,
   output logic                                              req_tready
);
   import irpir_pkg::*;

   logic               valid_ff, valid_in;
   logic [15:0]        data_ff, data_in;
   logic [VALUE_W-1:0] rd_any;
   logic [FACES-1:0]   ovf_bits;

   always_comb begin
      rd_any = '0;
      for (int i = 0; i < FACES; i++) begin
         rd_any      = rd_any | lane_res[i].rd;
         ovf_bits[i] = lane_res[i].ovf;
      end
   end

   assign req_tready = !valid_ff || rsp_tready;
   assign valid_in   = accept || (valid_ff && !rsp_tready);
   assign data_in    = accept ? {2'b00, OVF_W'(ovf_bits), rd_any} : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire

/* src/ir_pulse_interval_receiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse interval receiver
// Decodes bits from the gaps between IR pulses on each face of the device.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the sink keeps up and returns
// exactly one result item for each, in the cycle after acceptance, through a
// single output register. While a result waits for the sink the input is
// stalled; the next item enters in the same cycle in which the sink takes the
// waiting result, so with a ready sink items flow back to back with no gap.
// Each per-face lane measures the gap, checks the window and updates its state
// as the item is accepted. The item's tuser carries the opcode: a timer wrap
// tick, a pulse event on the faces in the mask at the given timestamp, a read
// of one face, or an idle item. Every result carries the read value (zero
// unless a full value was read and cleared) and the sticky overflow flags as
// they stand after the item. The user must write the gap window and the
// one/zero threshold through the csr port only while the block is idle; the
// block itself does not enforce this. A write to an unused index is ignored.
// ----------------------------------------------------------------------------
module ir_pulse_interval_receiver (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire [irpir_pkg::CSR_W-1:0] csr_index,
   input  wire [irpir_pkg::GAP_W-1:0] csr_wdata,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0: pulse_faces[5:0], timer_now[13:6], face[16:14].
   input  wire [23:0]                 req_tdata,
   // Fields from bit 0: opcode[1:0].
   input  wire [1:0]                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // Fields from bit 0: read_data[7:0], overflow_flags[13:8].
   output logic [15:0]                rsp_tdata
);
   import irpir_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic               accept;
   op_type             op;
   logic [5:0]         pulse_faces;
   logic [STAMP_W-1:0] timer_now;
   logic [FACE_W-1:0]  face;

   lane_cmd_type [FACES-1:0] lane_cmd;
   lane_res_type [FACES-1:0] lane_res;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GAP_MIN:   cfg_in.gap_min   = csr_wdata;
            CSR_GAP_MAX:   cfg_in.gap_max   = csr_wdata;
            CSR_ONE_LIMIT: cfg_in.one_limit = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_min   <= GAP_MIN_RST;
         cfg_ff.gap_max   <= GAP_MAX_RST;
         cfg_ff.one_limit <= ONE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the input item and hand each lane its share of it.
   assign accept      = req_tvalid && req_tready;
   assign op          = op_type'(req_tuser);
   assign pulse_faces = req_tdata[5:0];
   assign timer_now   = req_tdata[13:6];
   assign face        = req_tdata[16:14];

   for (genvar i = 0; i < FACES; i++) begin : g_lane
      assign lane_cmd[i].wrap  = accept && (op == OP_WRAP);
      assign lane_cmd[i].pulse = accept && (op == OP_PULSE) && pulse_faces[i];
      assign lane_cmd[i].read  = accept && (op == OP_READ) && (face == FACE_W'(i));
      assign lane_cmd[i].stamp = timer_now;

      irpir_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .cmd   (lane_cmd[i]),
         .res   (lane_res[i])
      );
   end

   // The merge stage ORs the read values (at most one lane reads) and
   // gathers the overflow flags into the registered result item.
   irpir_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .lane_res   (lane_res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .req_tready (req_tready)
   );

   logic [FACES-1:0] ovf_now;
   always_comb begin
      for (int i = 0; i < FACES; i++) begin
         ovf_now[i] = lane_res[i].ovf;
      end
   end

   // The block only stalls its input while a result is waiting.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   // Every accepted item produces a result in the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // Overflow flags are sticky until reset.
   a_ovf_sticky : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((ovf_now & $past(ovf_now)) == $past(ovf_now)))
      else $error("overflow flag dropped without reset");

   // Only a full value is ever returned by a read.
   a_read_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[7:0] != 8'h00)) |-> (rsp_tdata[3:2] == 2'b01))
      else $error("read returned a value that is not full");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse interval receiver testbench
// Drives timer wrap ticks, pulse events and face reads into the receiver,
// predicts every result item with a behavioral model of the per-face gap
// decoding, and checks the results in order under several gap windows and
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import irpir_pkg::*;

   // No stretch of this many cycles may pass without an item moving on
   // either side. The longest planned hold-off is far shorter.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 250;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      logic [OVF_W-1:0]   overflow;
      logic [VALUE_W-1:0] read_data;
   } face_result_type;

   // All inputs start at a known value before the first clock edge.
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [CSR_W-1:0]    csr_index  = '0;
   logic [GAP_W-1:0]    csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;

   // Predicted state of the receiver, kept in step with every accepted item.
   int                  cfg_gap_min   = GAP_MIN_RST;
   int                  cfg_gap_max   = GAP_MAX_RST;
   int                  cfg_one_limit = ONE_LIMIT_RST;
   logic [STAMP_W-1:0]  stamp_at [FACES];
   logic [VALUE_W-1:0]  face_value [FACES];
   logic [FACES-1:0]    wrap_seen     = '0;
   logic [FACES-1:0]    timed_out     = '0;
   logic [FACES-1:0]    overflow_seen = '0;

   face_result_type     due_results [$];
   int                  mismatches      = 0;
   int                  stim_count      = 0;
   int                  idle_cycles     = 0;
   int                  gen_ticks       = 0;
   int                  sender_idle_pct = 0;
   int                  sink_stall_pct  = 0;
   logic                sink_hold       = 1'b0;
   event                hold_start;

   ir_pulse_interval_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   initial begin
      for (int f = 0; f < FACES; f++) begin
         stamp_at[f]   = '0;
         face_value[f] = '0;
      end
   end

   // Advances the predicted receiver by one item and returns the result that
   // the item must produce. A face that has seen one wrap measures the gap
   // across the wrap; a second wrap expires the face so that its next pulse
   // only restarts timing.
   function automatic face_result_type receiver_step(op_type op, logic [FACES-1:0] faces,
                                                     logic [STAMP_W-1:0] now,
                                                     logic [FACE_W-1:0] face);
      face_result_type res;
      int              gap;
      logic            gap_ok;
      res.read_data = '0;
      case (op)
         OP_WRAP: begin
            timed_out = timed_out | wrap_seen;
            wrap_seen = '1;
         end
         OP_PULSE: begin
            for (int f = 0; f < FACES; f++) begin
               if (faces[f]) begin
                  if (!timed_out[f]) begin
                     if (wrap_seen[f]) begin
                        gap    = int'(TIMER_SPAN) - int'(stamp_at[f]) + int'(now);
                        gap_ok = 1'b1;
                     end else begin
                        gap    = int'(now) - int'(stamp_at[f]);
                        gap_ok = (gap >= 0);
                     end
                     if (gap_ok && gap > cfg_gap_min && gap < cfg_gap_max) begin
                        // A full value holds its bits; the new bit is lost
                        // and only the sticky overflow flag records it.
                        if ((face_value[f] & FULL_MASK) == FULL_CODE) begin
                           overflow_seen[f] = 1'b1;
                        end else begin
                           face_value[f] = {face_value[f][VALUE_W-2:0],
                                            gap <= cfg_one_limit};
                        end
                     end else begin
                        face_value[f] = '0;
                     end
                  end
                  stamp_at[f]  = now;
                  timed_out[f] = 1'b0;
                  wrap_seen[f] = 1'b0;
               end
            end
         end
         OP_READ: begin
            if (face < FACES) begin
               if ((face_value[face] & FULL_MASK) == FULL_CODE) begin
                  res.read_data    = face_value[face];
                  face_value[face] = '0;
               end
            end
         end
         default: begin
         end
      endcase
      res.overflow = overflow_seen;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s, got 0x%0h, expected 0x%0h", $realtime, what,
                  got, want);
      end
   endtask

   // Prediction and checking share one process so that an item accepted and
   // a result accepted at the same edge are always handled in that order.
   always @(posedge clock) begin
      face_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(receiver_step(op_type'(req_tuser), req_tdata[5:0],
                                                req_tdata[13:6], req_tdata[16:14]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("result with no item outstanding", int'(rsp_tdata), 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[7:0] !== want.read_data) begin
                  report_mismatch("read_data", int'(rsp_tdata[7:0]), int'(want.read_data));
               end
               if (rsp_tdata[13:8] !== want.overflow) begin
                  report_mismatch("overflow_flags", int'(rsp_tdata[13:8]),
                                  int'(want.overflow));
               end
            end
         end
      end
   end

   // Receiver side: ready at random, or held low for a long stretch on request.
   always @(posedge clock) begin
      if (sink_hold) begin
         rsp_tready <= 1'b0;
      end else if (sink_stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // The long hold-off counts its own cycles so that the sender keeps
   // offering items the whole time.
   initial begin
      forever begin
         @(hold_start);
         sink_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         sink_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one item and returns at the edge where it is accepted. The valid
   // stays high afterwards so that back-to-back items leave no bubble.
   task automatic send_item(op_type op, logic [FACES-1:0] faces, logic [STAMP_W-1:0] now,
                            logic [FACE_W-1:0] face);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, face, now, faces};
      do @(posedge clock); while (!req_tready);
      stim_count++;
   endtask

   // Stops offering, waits for the next edge so that the last accepted item is
   // surely logged, then waits until every outstanding result has come back,
   // plus a small margin.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the whole gap window. Only called while the block is idle.
   task automatic configure(int gmin, int gmax, int one, bit poke_unused);
      csr_we    <= 1'b1;
      csr_index <= CSR_GAP_MIN;
      csr_wdata <= GAP_W'(gmin);
      @(posedge clock);
      csr_index <= CSR_GAP_MAX;
      csr_wdata <= GAP_W'(gmax);
      @(posedge clock);
      csr_index <= CSR_ONE_LIMIT;
      csr_wdata <= GAP_W'(one);
      @(posedge clock);
      if (poke_unused) begin
         // The unused index must leave every register as it was.
         csr_index <= CSR_UNUSED;
         csr_wdata <= GAP_W'($urandom);
         @(posedge clock);
      end
      csr_we        <= 1'b0;
      cfg_gap_min   = gmin;
      cfg_gap_max   = gmax;
      cfg_one_limit = one;
   endtask

   // Random traffic. Most items follow a running timer: wrap ticks are sent
   // whenever the timer crosses a period, and pulses mostly land inside the
   // current window so that faces fill up and get read. The rest are reads,
   // idle opcodes and fully random items that break the timing.
   task automatic run_traffic(int n);
      int start;
      int pick;
      int lo;
      int hi;
      int delta;
      start = stim_count;
      while (stim_count - start < n) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            lo = cfg_gap_min + 1;
            hi = cfg_gap_max - 1;
            if (lo <= hi && $urandom_range(9) < 8) begin
               delta = $urandom_range(hi, lo);
            end else begin
               delta = $urandom_range(600, 0);
            end
            repeat ((gen_ticks + delta) / 256 - gen_ticks / 256) begin
               send_item(OP_WRAP, FACES'($urandom), STAMP_W'($urandom), FACE_W'($urandom));
            end
            gen_ticks += delta;
            send_item(OP_PULSE, ($urandom_range(1) == 1) ? {FACES{1'b1}} : FACES'($urandom),
                      STAMP_W'(gen_ticks), FACE_W'($urandom));
         end else if (pick < 82) begin
            send_item(OP_READ, FACES'($urandom), STAMP_W'($urandom),
                      ($urandom_range(9) == 0) ? FACE_W'($urandom_range(7, FACES))
                                               : FACE_W'($urandom_range(FACES - 1, 0)));
         end else if (pick < 87) begin
            send_item(OP_NONE, FACES'($urandom), STAMP_W'($urandom), FACE_W'($urandom));
         end else begin
            send_item(op_type'($urandom_range(3, 0)), FACES'($urandom), STAMP_W'($urandom),
                      FACE_W'($urandom));
         end
      end
   endtask

   // Hand-picked items under the reset window (10, 300, 200): an empty read,
   // a value built to full across timer wraps, an overflow, reads of faces
   // past the last one, the idle opcode, an expired face, a backward stamp,
   // and gaps right on each edge of the window and of the one/zero limit.
   task automatic test_directed_cases();
      send_item(OP_READ,  6'h00, 8'd0,   3'd0);
      send_item(OP_PULSE, 6'h3F, 8'd0,   3'd0);   // gap of zero clears all faces
      send_item(OP_PULSE, 6'h01, 8'd50,  3'd0);   // short gap, shifts a one
      send_item(OP_WRAP,  6'h00, 8'd0,   3'd0);
      send_item(OP_PULSE, 6'h01, 8'd50,  3'd0);   // gap of one whole period, a zero
      send_item(OP_WRAP,  6'h00, 8'd0,   3'd0);   // other faces expire here
      send_item(OP_PULSE, 6'h01, 8'd40,  3'd0);   // third bit makes face 0 full
      send_item(OP_READ,  6'h00, 8'd0,   3'd1);   // face 1 is not full
      send_item(OP_PULSE, 6'h01, 8'd100, 3'd0);   // valid bit while full: overflow
      send_item(OP_READ,  6'h00, 8'd0,   3'd0);   // returns the full value
      send_item(OP_READ,  6'h00, 8'd0,   3'd0);   // already cleared
      send_item(OP_READ,  6'h3F, 8'hFF,  3'd6);
      send_item(OP_READ,  6'h3F, 8'hFF,  3'd7);
      send_item(OP_NONE,  6'h3F, 8'hFF,  3'd7);
      send_item(OP_PULSE, 6'h02, 8'd30,  3'd0);   // expired face only restarts timing
      send_item(OP_PULSE, 6'h02, 8'd10,  3'd0);   // stamp went backward: clears
      send_item(OP_PULSE, 6'h02, 8'd20,  3'd0);   // gap equal to gap_min: clears
      send_item(OP_PULSE, 6'h02, 8'd220, 3'd0);   // gap equal to one_limit: a one
      send_item(OP_WRAP,  6'h00, 8'd0,   3'd0);
      send_item(OP_PULSE, 6'h02, 8'd165, 3'd0);   // one past one_limit: a zero
      send_item(OP_WRAP,  6'h00, 8'd0,   3'd0);
      send_item(OP_PULSE, 6'h02, 8'd209, 3'd0);   // gap equal to gap_max: clears
      send_item(OP_WRAP,  6'h00, 8'd0,   3'd0);
      send_item(OP_PULSE, 6'h02, 8'd252, 3'd0);   // one below gap_max: valid
      send_item(OP_PULSE, 6'h3F, 8'd255, 3'd0);
   endtask

   task automatic test_default_window();
      wait_drained();
      configure(GAP_MIN_RST, GAP_MAX_RST, ONE_LIMIT_RST, 1'b0);
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      run_traffic(250);
   endtask

   task automatic test_sparse_sender();
      wait_drained();
      configure(20, 400, 100, 1'b0);
      sender_idle_pct = 77;
      sink_stall_pct  = 0;
      run_traffic(250);
   endtask

   // Widest window: every gap from 1 to 510 is valid and decodes as a one.
   task automatic test_stalled_receiver();
      wait_drained();
      configure(0, 511, 511, 1'b1);
      sender_idle_pct = 0;
      sink_stall_pct  = 77;
      run_traffic(250);
   endtask

   task automatic test_mixed_idling();
      wait_drained();
      configure(5, 200, 60, 1'b0);
      sender_idle_pct = 7;
      sink_stall_pct  = 7;
      run_traffic(250);
   endtask

   // Closed window: no gap can ever be valid, so every measured pulse clears.
   task automatic test_closed_window();
      wait_drained();
      configure(511, 0, 0, 1'b1);
      sender_idle_pct = 7;
      sink_stall_pct  = 7;
      run_traffic(100);
   endtask

   // The receiver stops for a long stretch while the sender keeps offering,
   // so the output register fills and the block must stall its input. Then
   // the sender pauses until every result has drained.
   task automatic test_backpressure();
      wait_drained();
      configure(GAP_MIN_RST, GAP_MAX_RST, ONE_LIMIT_RST, 1'b0);
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      -> hold_start;
      run_traffic(60);
      wait_drained();
      sender_idle_pct = 7;
      sink_stall_pct  = 7;
      run_traffic(150);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_default_window();
      test_sparse_sender();
      test_stalled_receiver();
      test_mixed_idling();
      test_closed_window();
      test_backpressure();
      wait_drained();
      if (due_results.size() != 0) begin
         report_mismatch("results never returned", 0, due_results.size());
      end
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
